// ===== sv/pidc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the clamped PID controller.
// No dependencies; imported by pidc_mul, pidc_div and pid_controller_clamped.
package pidc_pkg;

    localparam int WORD_W     = 32;                 // Q16.16 word
    localparam int DT_W       = 31;                 // loop period width
    localparam int FRAC_W     = 16;                 // fraction bits
    localparam int PROD_W     = 2 * WORD_W;         // full product width
    localparam int TERM_W     = PROD_W - FRAC_W;    // product after the shift
    localparam int SUM_W      = TERM_W + 2;         // room for three terms
    localparam int MUL_DIGIT  = 2;                  // multiplier bits per cycle
    localparam int MUL_STEPS  = WORD_W / MUL_DIGIT;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int NUM_W      = WORD_W + FRAC_W;    // derivative dividend width
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd7;

    localparam logic [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [DT_W-1:0]   DT_ONE_Q = {{(DT_W-FRAC_W-1){1'b0}}, 1'b1, {FRAC_W{1'b0}}};

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;   // working on an operation
        logic done;   // one-cycle pulse, result valid from here on
    } t_unit_stat;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic [WORD_W-1:0] sat32(input logic [SUM_W-1:0] v);
        logic top_same;
        top_same = (&v[SUM_W-1:WORD_W-1]) || (~|v[SUM_W-1:WORD_W-1]);
        if (top_same) begin
            return v[WORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return S32_MIN;
        end else begin
            return S32_MAX;
        end
    endfunction

    // Floor is tested first: with crossed limits, values below the floor give the floor and all others the ceiling.
    function automatic logic [WORD_W-1:0] clamp32(input logic [WORD_W-1:0] v,
                                                  input logic [WORD_W-1:0] lo,
                                                  input logic [WORD_W-1:0] hi);
        if ($signed(v) < $signed(lo)) begin
            return lo;
        end else if ($signed(v) > $signed(hi)) begin
            return hi;
        end else begin
            return v;
        end
    endfunction

    // Apply the sign to an unsigned quotient and saturate it to 32 bits.
    function automatic logic [WORD_W-1:0] signed_quot(input logic [NUM_W-1:0] q,
                                                      input logic neg);
        logic over_pos;
        logic over_neg;
        over_pos = |q[NUM_W-1:WORD_W-1];
        over_neg = (|q[NUM_W-1:WORD_W]) || (q[WORD_W-1] && (|q[WORD_W-2:0]));
        if (!neg) begin
            return over_pos ? S32_MAX : q[WORD_W-1:0];
        end else begin
            return over_neg ? S32_MIN : (~q[WORD_W-1:0] + 1'b1);
        end
    endfunction

endpackage

// ===== sv/pidc_mul.sv =====
`timescale 1ns / 1ps
// Shared radix-4 shift-add multiplier, signed 32 x 32 to 64 bits.
// Depends on pidc_pkg.
module pidc_mul
    import pidc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_mcand,
    input  logic [WORD_W-1:0] i_mplier,
    output t_unit_stat        o_stat,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0]    r_acc;
    logic [PROD_W-1:0]    r_m1;
    logic [PROD_W-1:0]    r_m3;
    logic [WORD_W-1:0]    r_mplier;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [PROD_W-1:0]    n_acc;
    logic [PROD_W-1:0]    w_term;
    logic                 w_sub;
    logic                 w_last;
    logic [PROD_W-1:0]    w_mcand_ext;

    assign w_last      = (r_cnt == MUL_CNT_W'(MUL_STEPS - 1));
    assign w_mcand_ext = {{(PROD_W-WORD_W){i_mcand[WORD_W-1]}}, i_mcand};

    // The top digit of the multiplier is signed, the others are not.
    always_comb begin
        w_term = '0;
        w_sub  = 1'b0;
        unique case ({w_last, r_mplier[MUL_DIGIT-1:0]})
            3'b000, 3'b100: w_term = '0;
            3'b001, 3'b101: w_term = r_m1;
            3'b010:         w_term = {r_m1[PROD_W-2:0], 1'b0};
            3'b011:         w_term = r_m3;
            3'b110: begin
                w_term = {r_m1[PROD_W-2:0], 1'b0};
                w_sub  = 1'b1;
            end
            3'b111: begin
                w_term = r_m1;
                w_sub  = 1'b1;
            end
        endcase
        n_acc = w_sub ? (r_acc - w_term) : (r_acc + w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !w_last;
            r_done <= w_last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_m1     <= w_mcand_ext;
            r_m3     <= {w_mcand_ext[PROD_W-2:0], 1'b0} + w_mcand_ext;
            r_mplier <= i_mplier;
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_m1     <= {r_m1[PROD_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
            r_m3     <= {r_m3[PROD_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
            r_mplier <= {{MUL_DIGIT{1'b0}}, r_mplier[WORD_W-1:MUL_DIGIT]};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_prod      = r_acc;

endmodule

// ===== sv/pidc_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, 48-bit unsigned dividend by 31-bit divisor.
// Depends on pidc_pkg.
module pidc_div
    import pidc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DT_W-1:0]  i_den,
    output t_unit_stat       o_stat,
    output logic [NUM_W-1:0] o_quot
);

    // r_num shifts dividend bits out at the top and quotient bits in at the bottom.
    logic [NUM_W-1:0]     r_num;
    logic [DT_W-1:0]      r_rem;
    logic [DT_W-1:0]      r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DT_W:0]        w_rem_sh;
    logic [DT_W+1:0]      w_diff;
    logic                 w_ge;
    logic                 w_last;

    assign w_rem_sh = {r_rem, r_num[NUM_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, r_den};
    assign w_ge     = !w_diff[DT_W+1];
    assign w_last   = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + 1'b1;
            r_busy <= !w_last;
            r_done <= w_last;
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DT_W-1:0] : w_rem_sh[DT_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_num;

endmodule

// ===== sv/pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Top level of the clamped PID controller: stream ports, registers, sequencer.
// Depends on pidc_pkg, pidc_mul and pidc_div.
//
// One PID loop in signed Q16.16. An input word with tuser low runs one update:
// error = setpoint - measurement, the integral takes error * dt and is clamped
// to its limits, the derivative is (error - last error) / dt, and the drive
// kp * error + ki * integral + kd * derivative is clamped to the drive limits
// and sent as one output word. Products are taken exactly and shifted right by
// 16 toward minus infinity; error, integral and derivative saturate to 32
// bits, as does the drive sum before its clamp. An input word with tuser
// high clears the integral and the last error and sends 0. An update
// reaches the output register through a setup state, four products that
// run one after the other on a single radix-4 shift-add multiplier that
// retires two multiplier bits per cycle, and the output state. The
// bit-serial divider for the derivative starts with the first product and
// finishes during the third, so it adds no time. The input is ready again
// as soon as the result is loaded; a clear goes straight to the output
// state. The input is ready whenever the sequencer is idle; a
// finished word sits in the output register, so the next input word can be
// taken while the previous result waits. If that word is still not taken when
// the next result is done, the sequencer holds the new result and the input
// stays stalled until the output register frees up. The configuration
// registers are written through the plain write port and must only be changed
// while no update is in flight. A time step of zero acts as the smallest step.
module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [2*WORD_W-1:0]   s_axis_tdata,   // [31:0] setpoint, [63:32] measurement
    input  logic                  s_axis_tuser,   // [0] action: 0 update, 1 clear
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WORD_W-1:0]     m_axis_tdata    // [31:0] drive
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PREP   = 3'd1;
    localparam logic [2:0] ST_MUL_DT = 3'd2;
    localparam logic [2:0] ST_MUL_P  = 3'd3;
    localparam logic [2:0] ST_MUL_I  = 3'd4;
    localparam logic [2:0] ST_WAIT_D = 3'd5;
    localparam logic [2:0] ST_MUL_D  = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // Configuration registers.
    logic [WORD_W-1:0] r_prop_gain;
    logic [WORD_W-1:0] r_integ_gain;
    logic [WORD_W-1:0] r_deriv_gain;
    logic [DT_W-1:0]   r_time_step;
    logic [WORD_W-1:0] r_integ_floor;
    logic [WORD_W-1:0] r_integ_ceiling;
    logic [WORD_W-1:0] r_drive_floor;
    logic [WORD_W-1:0] r_drive_ceiling;

    // Loop state and datapath registers.
    logic [2:0]        r_state,     n_state;
    logic [WORD_W-1:0] r_err,       n_err;
    logic [WORD_W-1:0] r_last,      n_last;
    logic [WORD_W-1:0] r_integ,     n_integ;
    logic [SUM_W-1:0]  r_sum,       n_sum;
    logic [WORD_W-1:0] r_res,       n_res;
    logic              r_dneg,      n_dneg;
    logic [WORD_W-1:0] r_drive,     n_drive;
    logic              r_out_valid, n_out_valid;

    logic              w_in_acc;
    logic [DT_W-1:0]   w_dt;
    logic [WORD_W:0]   w_in_diff;
    logic [WORD_W:0]   w_err_diff;
    logic [WORD_W-1:0] w_err_mag;
    logic [SUM_W-1:0]  w_term;
    logic [SUM_W-1:0]  w_integ_sum;
    logic [SUM_W-1:0]  w_out_sum;

    logic              w_mul_start;
    logic [WORD_W-1:0] w_mul_a;
    logic [WORD_W-1:0] w_mul_b;
    t_unit_stat        w_mul_stat;
    logic [PROD_W-1:0] w_mul_prod;

    logic              w_div_start;
    t_unit_stat        w_div_stat;
    logic [NUM_W-1:0]  w_div_quot;

    pidc_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mul_a),
        .i_mplier (w_mul_b),
        .o_stat   (w_mul_stat),
        .o_prod   (w_mul_prod)
    );

    pidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_err_mag, {FRAC_W{1'b0}}}),
        .i_den   (w_dt),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;

    // A zero time step behaves as the smallest step.
    assign w_dt = (r_time_step == '0) ? DT_W'(1) : r_time_step;

    assign w_in_diff = {s_axis_tdata[WORD_W-1], s_axis_tdata[WORD_W-1:0]}
                     - {s_axis_tdata[2*WORD_W-1], s_axis_tdata[2*WORD_W-1:WORD_W]};

    // The error difference needs 33 bits; its magnitude always fits in 32.
    assign w_err_diff = {r_err[WORD_W-1], r_err} - {r_last[WORD_W-1], r_last};
    assign w_err_mag  = w_err_diff[WORD_W] ? WORD_W'(-w_err_diff) : w_err_diff[WORD_W-1:0];

    // Product shifted right by 16 bits, which is a floor for signed values.
    assign w_term      = {{(SUM_W-TERM_W){w_mul_prod[PROD_W-1]}}, w_mul_prod[PROD_W-1:FRAC_W]};
    assign w_integ_sum = {{(SUM_W-WORD_W){r_integ[WORD_W-1]}}, r_integ} + w_term;
    assign w_out_sum   = r_sum + w_term;

    always_comb begin
        n_state     = r_state;
        n_err       = r_err;
        n_last      = r_last;
        n_integ     = r_integ;
        n_sum       = r_sum;
        n_res       = r_res;
        n_dneg      = r_dneg;
        n_drive     = r_drive;
        n_out_valid = r_out_valid;
        w_mul_start = 1'b0;
        w_mul_a     = r_err;
        w_mul_b     = {1'b0, w_dt};
        w_div_start = 1'b0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser) begin
                        n_integ = '0;
                        n_last  = '0;
                        n_res   = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_err   = sat32({{(SUM_W-WORD_W-1){w_in_diff[WORD_W]}}, w_in_diff});
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                // error * dt on the multiplier, the derivative on the divider.
                w_mul_start = 1'b1;
                w_div_start = 1'b1;
                n_dneg      = w_err_diff[WORD_W];
                n_last      = r_err;
                n_sum       = '0;
                n_state     = ST_MUL_DT;
            end
            ST_MUL_DT: begin
                if (w_mul_stat.done) begin
                    n_integ     = clamp32(sat32(w_integ_sum), r_integ_floor, r_integ_ceiling);
                    w_mul_start = 1'b1;
                    w_mul_a     = r_prop_gain;
                    w_mul_b     = r_err;
                    n_state     = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                if (w_mul_stat.done) begin
                    n_sum       = w_out_sum;
                    w_mul_start = 1'b1;
                    w_mul_a     = r_integ_gain;
                    w_mul_b     = r_integ;
                    n_state     = ST_MUL_I;
                end
            end
            ST_MUL_I: begin
                if (w_mul_stat.done) begin
                    n_sum   = w_out_sum;
                    n_state = ST_WAIT_D;
                end
            end
            ST_WAIT_D: begin
                if (!w_div_stat.busy) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_deriv_gain;
                    w_mul_b     = signed_quot(w_div_quot, r_dneg);
                    n_state     = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                if (w_mul_stat.done) begin
                    n_res   = clamp32(sat32(w_out_sum), r_drive_floor, r_drive_ceiling);
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_drive     = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_last      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err   <= n_err;
        r_sum   <= n_sum;
        r_res   <= n_res;
        r_dneg  <= n_dneg;
        r_drive <= n_drive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= '0;
            r_integ_gain    <= '0;
            r_deriv_gain    <= '0;
            r_time_step     <= DT_ONE_Q;
            r_integ_floor   <= S32_MIN;
            r_integ_ceiling <= S32_MAX;
            r_drive_floor   <= S32_MIN;
            r_drive_ceiling <= S32_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:     r_prop_gain     <= i_cfg_wdata;
                REG_INTEG_GAIN:    r_integ_gain    <= i_cfg_wdata;
                REG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_wdata;
                REG_TIME_STEP:     r_time_step     <= i_cfg_wdata[DT_W-1:0];
                REG_INTEG_FLOOR:   r_integ_floor   <= i_cfg_wdata;
                REG_INTEG_CEILING: r_integ_ceiling <= i_cfg_wdata;
                REG_DRIVE_FLOOR:   r_drive_floor   <= i_cfg_wdata;
                REG_DRIVE_CEILING: r_drive_ceiling <= i_cfg_wdata;
            endcase
        end
    end

    // The shared units are never restarted while they are still working.
    a_mul_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> !w_mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider started while busy");

    // A clear word always produces a zero result.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && s_axis_tuser) |=> (r_res == '0 && r_integ == '0 && r_last == '0))
        else $error("clear did not zero the loop state");

    // With ordered limits the freshly updated integral lies inside them.
    a_integ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == ST_MUL_P) && $signed(r_integ_floor) <= $signed(r_integ_ceiling))
        |-> ($signed(r_integ) >= $signed(r_integ_floor)
             && $signed(r_integ) <= $signed(r_integ_ceiling)))
        else $error("integral outside its limits");

endmodule

// ===== test/tb_pid_controller_clamped.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the clamped PID controller: directed and random words
// against a built-in Q16.16 predictor, with random idles and output back-pressure.
// Depends on pidc_pkg and pid_controller_clamped.
module tb_pid_controller_clamped;
    import pidc_pkg::*;

    typedef enum logic {
        ACT_UPDATE = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_pid_action;

    localparam logic [WORD_W-1:0] Q_ONE        = 32'h0001_0000;
    localparam longint            WORD_MAX_L   = 64'sd2147483647;
    localparam longint            WORD_MIN_L   = -64'sd2147483648;
    localparam int                LONG_HOLD    = 400;
    localparam int                PRINT_BUDGET = 20;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [2*WORD_W-1:0]  s_axis_tdata;   // [31:0] setpoint, [63:32] measurement
    logic                 s_axis_tuser;   // [0] action: 0 update, 1 clear
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [WORD_W-1:0]    m_axis_tdata;   // [31:0] drive

    // Predictor copy of the registers, in index order, at their reset values.
    logic [WORD_W-1:0] loop_regs [8] = '{32'h0, 32'h0, 32'h0, Q_ONE,
                                         S32_MIN, S32_MAX, S32_MIN, S32_MAX};
    longint            integ_acc  = 0;
    longint            prev_error = 0;
    logic [WORD_W-1:0] drive_queue [$];

    int  words_sent       = 0;
    int  clears_sent      = 0;
    int  settings_applied = 0;
    int  results_checked  = 0;
    int  error_count      = 0;
    int  burst_left       = 0;
    bit  gaps_on          = 1'b1;
    bit  hold_request     = 1'b0;

    pid_controller_clamped dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint as_signed(input logic [WORD_W-1:0] w);
        return longint'($signed(w));
    endfunction

    function automatic longint saturate_word(input longint v);
        if (v > WORD_MAX_L) return WORD_MAX_L;
        if (v < WORD_MIN_L) return WORD_MIN_L;
        return v;
    endfunction

    // Exact product, then an arithmetic shift, which rounds toward minus infinity.
    function automatic longint fixed_mul(input longint a, input longint b);
        return (a * b) >>> FRAC_W;
    endfunction

    // Floor first: with crossed limits, values below the floor give the floor and all others the ceiling.
    function automatic longint limit_range(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [WORD_W-1:0] predict_drive(input t_pid_action act,
                                                        input logic [WORD_W-1:0] sp,
                                                        input logic [WORD_W-1:0] meas);
        longint err;
        longint dt;
        longint slope;
        longint total;
        if (act == ACT_CLEAR) begin
            integ_acc  = 0;
            prev_error = 0;
            return '0;
        end
        dt = loop_regs[REG_TIME_STEP][DT_W-1:0];
        if (dt == 0) dt = 1;   // a zero step behaves as the smallest step
        err = saturate_word(as_signed(sp) - as_signed(meas));
        integ_acc = saturate_word(integ_acc + fixed_mul(err, dt));
        integ_acc = limit_range(integ_acc, as_signed(loop_regs[REG_INTEG_FLOOR]),
                                as_signed(loop_regs[REG_INTEG_CEILING]));
        // Quotient truncates toward zero, as signed integer division does.
        slope = saturate_word(((err - prev_error) * 65536) / dt);
        total = fixed_mul(as_signed(loop_regs[REG_PROP_GAIN]), err)
              + fixed_mul(as_signed(loop_regs[REG_INTEG_GAIN]), integ_acc)
              + fixed_mul(as_signed(loop_regs[REG_DERIV_GAIN]), slope);
        total = limit_range(saturate_word(total), as_signed(loop_regs[REG_DRIVE_FLOOR]),
                            as_signed(loop_regs[REG_DRIVE_CEILING]));
        prev_error = err;
        return total[WORD_W-1:0];
    endfunction

    // ---------------------------------------------------------------- drivers

    // Writes all eight registers back to back; only called with the loop idle.
    task automatic apply_settings(input logic [WORD_W-1:0] kp, input logic [WORD_W-1:0] ki,
                                  input logic [WORD_W-1:0] kd, input logic [WORD_W-1:0] dt,
                                  input logic [WORD_W-1:0] i_lo, input logic [WORD_W-1:0] i_hi,
                                  input logic [WORD_W-1:0] d_lo, input logic [WORD_W-1:0] d_hi);
        logic [WORD_W-1:0] vals [8];
        vals[REG_PROP_GAIN]     = kp;
        vals[REG_INTEG_GAIN]    = ki;
        vals[REG_DERIV_GAIN]    = kd;
        vals[REG_TIME_STEP]     = dt;
        vals[REG_INTEG_FLOOR]   = i_lo;
        vals[REG_INTEG_CEILING] = i_hi;
        vals[REG_DRIVE_FLOOR]   = d_lo;
        vals[REG_DRIVE_CEILING] = d_hi;
        for (int r = 0; r < 8; r++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_wdata <= vals[r];
            @(posedge i_clk);
            loop_regs[r] = (r == REG_TIME_STEP) ? {1'b0, vals[r][DT_W-1:0]} : vals[r];
        end
        i_cfg_wr_en <= 1'b0;
        settings_applied++;
    endtask

    // Offers one word and returns at the edge that accepts it. Valid stays high
    // on return, so back-to-back words never drop it in between.
    task automatic send_word(input t_pid_action act, input logic [WORD_W-1:0] sp,
                             input logic [WORD_W-1:0] meas);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {meas, sp};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        drive_queue.push_back(predict_drive(act, sp, meas));
        if (burst_left > 0) burst_left--;
        words_sent++;
        if (act == ACT_CLEAR) clears_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- receiver

    // Ready follows a pattern that is chosen anew at random intervals: always
    // ready, mostly ready, or ready with occasional random stalls. A hold
    // request from the stimulus side forces one long stall.
    initial begin : receiver
        int mode;
        int mode_left;
        int stall_left;
        mode       = 0;
        mode_left  = 0;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (mode == 2 && stall_left == 0 && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(5, 60);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (mode == 1) begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- checker

    always @(posedge i_clk) begin : drive_checker
        logic [WORD_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (drive_queue.size() == 0) begin
                error_count++;
                if (error_count <= PRINT_BUDGET)
                    $display("%0t ns: drive word %h arrived with nothing pending",
                             $time, m_axis_tdata);
            end else begin
                want = drive_queue.pop_front();
                results_checked++;
                if (m_axis_tdata !== want) begin
                    error_count++;
                    $display("%0t ns: drive mismatch, expected %h (%0d), got %h (%0d)",
                             $time, want, $signed(want), m_axis_tdata,
                             $signed(m_axis_tdata));
                end
            end
        end
    end

    // ---------------------------------------------------------------- random choices

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return WORD_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
            default: return $urandom();
        endcase
    endfunction

    // Gains stay mostly within +-4.0 so the drive is not always pinned.
    function automatic logic [WORD_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return S32_MAX;
            1:       return S32_MIN;
            2:       return '0;
            3:       return $urandom();
            default: return WORD_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    // Bit 31 of the written step is random too; the block keeps only 31 bits.
    function automatic logic [WORD_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return $urandom();
            default: return {$urandom_range(0, 1) == 1, 31'($urandom_range(32'h100, 32'h40000))};
        endcase
    endfunction

    task automatic pick_limits(output logic [WORD_W-1:0] lo, output logic [WORD_W-1:0] hi);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = pick_value();
        b = pick_value();
        case ($urandom_range(0, 4))
            0: begin
                lo = S32_MIN;
                hi = S32_MAX;
            end
            1: begin
                // Crossed: floor above ceiling.
                lo = ($signed(a) > $signed(b)) ? a : b;
                hi = ($signed(a) > $signed(b)) ? b : a;
            end
            default: begin
                lo = ($signed(a) < $signed(b)) ? a : b;
                hi = ($signed(a) < $signed(b)) ? b : a;
            end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // Right after reset all gains are zero, so every drive is 0, even when the
    // error saturates in either direction.
    task automatic test_reset_defaults();
        send_word(ACT_UPDATE, S32_MAX, S32_MIN);
        send_word(ACT_UPDATE, S32_MIN, S32_MAX);
        send_word(ACT_CLEAR, 32'h1234_5678, 32'h9ABC_DEF0);
        send_word(ACT_UPDATE, '0, '0);
    endtask

    // Plain gains of 1.0, 0.5 and 0.25 with modest limits; the last update
    // after a clear starts the integral and derivative from zero again.
    task automatic test_unit_gains();
        drain_results();
        apply_settings(Q_ONE, 32'h0000_8000, 32'h0000_4000, Q_ONE,
                       -32'sh000A_0000, 32'h000A_0000, -32'sh0014_0000, 32'h0014_0000);
        send_word(ACT_UPDATE, 32'h0003_0000, 32'h0001_0000);
        send_word(ACT_UPDATE, -32'sh0002_8000, 32'h0000_8000);
        send_word(ACT_UPDATE, S32_MAX, S32_MIN);
        send_word(ACT_CLEAR, '0, '0);
        send_word(ACT_UPDATE, Q_ONE, '0);
    endtask

    // Zero step, crossed limits on both clamps, and a step written with bit 31 set.
    task automatic test_special_cases();
        drain_results();
        apply_settings('0, Q_ONE, Q_ONE, '0, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        send_word(ACT_UPDATE, 32'h0000_0003, '0);
        send_word(ACT_UPDATE, -32'sh0000_0005, 32'h0000_0002);
        drain_results();
        apply_settings(Q_ONE, Q_ONE, '0, Q_ONE, 32'h0005_0000, -32'sh0005_0000,
                       32'h0003_0000, -32'sh0003_0000);
        send_word(ACT_UPDATE, 32'h000A_0000, '0);
        send_word(ACT_UPDATE, -32'sh000A_0000, '0);
        send_word(ACT_UPDATE, Q_ONE, '0);
        drain_results();
        apply_settings(Q_ONE, '0, Q_ONE, 32'h8001_0000, S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        send_word(ACT_UPDATE, 32'h0002_0000, '0);
    endtask

    // Gains at both ends of their range with the longest and shortest steps.
    task automatic test_gain_extremes();
        drain_results();
        apply_settings(S32_MIN, S32_MAX, S32_MIN, 32'h7FFF_FFFF,
                       S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        send_word(ACT_UPDATE, S32_MAX, S32_MIN);
        send_word(ACT_UPDATE, S32_MIN, S32_MAX);
        send_word(ACT_UPDATE, 32'h1234_5678, 32'h9ABC_DEF0);
        drain_results();
        apply_settings(S32_MAX, S32_MIN, S32_MAX, 32'h0000_0001,
                       S32_MIN, S32_MAX, S32_MIN, S32_MAX);
        send_word(ACT_UPDATE, 32'h0000_0001, '0);
        send_word(ACT_UPDATE, '1, '0);
        send_word(ACT_UPDATE, S32_MAX, S32_MIN);
    endtask

    // The receiver stops for a long stretch while words keep coming with no
    // gaps, so the output register and the sequencer fill and input stalls.
    task automatic test_backpressure();
        drain_results();
        apply_settings(Q_ONE, 32'h0000_4000, 32'h0000_2000, Q_ONE,
                       -32'sh0064_0000, 32'h0064_0000, S32_MIN, S32_MAX);
        gaps_on      = 1'b0;
        hold_request = 1'b1;
        repeat (10)
            send_word(ACT_UPDATE, pick_value(), pick_value());
        gaps_on = 1'b1;
    endtask

    // Phases of random settings, each followed by a run of random words. Most
    // measurements sit near the setpoint so the loop works off the rails.
    task automatic test_random_settings();
        logic [WORD_W-1:0] i_lo;
        logic [WORD_W-1:0] i_hi;
        logic [WORD_W-1:0] d_lo;
        logic [WORD_W-1:0] d_hi;
        logic [WORD_W-1:0] sp;
        logic [WORD_W-1:0] meas;
        t_pid_action       act;
        int                count;
        for (int p = 0; p < 9; p++) begin
            drain_results();
            pick_limits(i_lo, i_hi);
            pick_limits(d_lo, d_hi);
            apply_settings(pick_gain(), pick_gain(), pick_gain(), pick_step(),
                           i_lo, i_hi, d_lo, d_hi);
            count = $urandom_range(110, 150);
            repeat (count) begin
                act  = ($urandom_range(0, 19) == 0) ? ACT_CLEAR : ACT_UPDATE;
                sp   = pick_value();
                meas = ($urandom_range(0, 3) == 0) ? pick_value()
                     : sp - (WORD_W'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF);
                send_word(act, sp, meas);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_UPDATE;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_unit_gains();
        test_special_cases();
        test_gain_extremes();
        test_backpressure();
        test_random_settings();

        drain_results();
        repeat (100) @(posedge i_clk);
        if (drive_queue.size() != 0) begin
            error_count++;
            $display("%0t ns: %0d drive words never arrived", $time, drive_queue.size());
        end

        $display("Sent %0d words (%0d clears) under %0d register settings.",
                 words_sent, clears_sent, settings_applied);
        $display("Checked %0d drive words, %0d failures.", results_checked, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Far beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pidc_pkg.sv
sv/pidc_mul.sv
sv/pidc_div.sv
sv/pid_controller_clamped.sv
test/tb_pid_controller_clamped.sv
